FILE: rtl/hgm_pkg.sv
// hgm_pkg: shared constants and codes for the height grid occupancy mapper
// no dependencies

package hgm_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int CELL_AW     = $clog2(GRID_CELLS);

    // one ram word holds {hits, height}
    localparam int HITS_W = 16;
    localparam int AVG_W  = 32;
    localparam int CELL_W = HITS_W + AVG_W;

    // shared multiplier: signed A x signed B
    localparam int MUL_AW = 34;
    localparam int MUL_BW = 18;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // shared divider
    localparam int DIV_NW = 49;
    localparam int DIV_DW = 31;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_AW-1:0] REG_CELL_SCALE     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_OBSTACLE_LIMIT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ROBOT_ROW      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ROBOT_COL      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_OFFSET_X       = 3'd4;
    localparam logic [CFG_AW-1:0] REG_OFFSET_Y       = 3'd5;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [MUL_BW-1:0] OCC_SCALE = 18'd100;
    localparam logic signed [7:0] OCC_FULL    = 8'sd100;
    localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic                start;
        logic [DIV_NW-1:0]   dividend;
        logic [DIV_DW-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_NW-1:0]   quotient;
    } t_div_rsp;

endpackage

FILE: rtl/hgm_ram.sv
// hgm_ram: generic single write port ram with registered read
// no dependencies

module hgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/hgm_div.sv
// hgm_div: unsigned restoring divider, one quotient bit per cycle
// depends on hgm_pkg

module hgm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hgm_pkg::t_div_req i_req,
    output hgm_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic [$clog2(hgm_pkg::DIV_NW)-1:0] r_cnt;
    logic [hgm_pkg::DIV_NW-1:0]     r_quo;
    logic [hgm_pkg::DIV_DW-1:0]     r_rem;
    logic [hgm_pkg::DIV_DW-1:0]     r_dsr;
    logic                           r_done;
    logic [hgm_pkg::DIV_DW:0]       rem_sh;
    logic                           fits;

    assign rem_sh = {r_rem, r_quo[hgm_pkg::DIV_NW-1]};
    assign fits   = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ($clog2(hgm_pkg::DIV_NW))'(hgm_pkg::DIV_NW - 1);
                r_quo  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? hgm_pkg::DIV_DW'(rem_sh - {1'b0, r_dsr})
                              : hgm_pkg::DIV_DW'(rem_sh);
                r_quo <= {r_quo[hgm_pkg::DIV_NW-2:0], fits};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: rtl/height_grid_occupancy_mapper.sv
// height_grid_occupancy_mapper: top level, sequencer around one multiplier and one divider
// depends on hgm_pkg, hgm_ram, hgm_div
//
// channel   dir  fields (low bit up)
// s_axis    in   action[1:0] point_x[33:2] point_y[65:34] point_z[97:66] cell_index[109:98]
// m_axis    out  occupancy[7:0] accepted[8]
// cfg       in   write enable, register index, 32-bit data
//
// add: binning multiplies, then a multiply and the divider for the running average
// read: the divider runs only when the occupancy must be scaled; unused action: result at accept
// clear: writes every ram word, one per cycle; the same pass runs after reset
// input ready only when idle and the result register is empty or being taken

module height_grid_occupancy_mapper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hgm_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // action, point_x, point_y, point_z, cell_index
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hgm_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // occupancy, accepted
    input  logic                            i_cfg_we,
    input  logic [hgm_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [hgm_pkg::CFG_DW-1:0]      i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MX, S_MY, S_BIN, S_AMUL, S_ASUM, S_ADIV, S_RCHK, S_RMUL, S_RDIV
    } t_state;

    t_state r_state;

    logic [15:0]        r_scale;
    logic [30:0]        r_limit;
    logic [5:0]         r_rrow;
    logic [5:0]         r_rcol;
    logic signed [31:0] r_offx;
    logic signed [31:0] r_offy;

    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_pz;

    logic [hgm_pkg::CELL_AW-1:0] r_clr_cnt;
    logic                        r_clr_item;
    logic [hgm_pkg::CELL_AW-1:0] r_addr;
    logic signed [28:0]          r_col;
    logic [hgm_pkg::HITS_W-1:0]  r_hits;
    logic                        r_neg;
    logic signed [hgm_pkg::MUL_PW-1:0] r_prod;

    logic                        r_ovalid;
    logic signed [7:0]           r_occ;
    logic                        r_acc;

    logic                        s_acc;
    logic [1:0]                  in_act;
    logic [11:0]                 in_idx;
    logic                        idx_ok;

    logic signed [hgm_pkg::MUL_AW-1:0] mul_a;
    logic signed [hgm_pkg::MUL_BW-1:0] mul_b;

    logic [hgm_pkg::MUL_PW-1:0]  bin_mag;
    logic signed [28:0]          bin_cells;
    logic signed [28:0]          bin_coord;
    logic [5:0]                  bin_base;
    logic                        row_ok;
    logic                        col_ok;
    logic [hgm_pkg::CELL_AW-1:0] add_addr;

    logic [hgm_pkg::CELL_W-1:0]  ram_rdata;
    logic [hgm_pkg::CELL_W-1:0]  ram_wdata;
    logic [hgm_pkg::CELL_AW-1:0] ram_raddr;
    logic [hgm_pkg::CELL_AW-1:0] ram_waddr;
    logic                        ram_we;
    logic [hgm_pkg::HITS_W-1:0]  rd_hits;
    logic signed [31:0]          rd_avg;
    logic [31:0]                 rd_mag;

    logic signed [hgm_pkg::MUL_PW-1:0] num;
    logic [hgm_pkg::MUL_PW-1:0]  num_mag;
    logic [31:0]                 new_avg;
    logic [hgm_pkg::HITS_W-1:0]  new_hits;

    hgm_pkg::t_div_req div_req;
    hgm_pkg::t_div_rsp div_rsp;

    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign in_act = s_axis_tdata[1:0];
    assign in_idx = s_axis_tdata[109:98];
    assign idx_ok = 32'(in_idx) < hgm_pkg::GRID_CELLS;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MX: begin
                mul_a = hgm_pkg::MUL_AW'(33'(r_px) - 33'(r_offx));
                mul_b = {2'b0, r_scale};
            end
            S_MY: begin
                mul_a = hgm_pkg::MUL_AW'(33'(r_py) - 33'(r_offy));
                mul_b = {2'b0, r_scale};
            end
            S_AMUL: begin
                mul_a = hgm_pkg::MUL_AW'(rd_avg);
                mul_b = {2'b0, rd_hits};
            end
            S_RCHK: begin
                mul_a = {2'b0, rd_mag};
                mul_b = hgm_pkg::OCC_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // truncate binning product toward zero, add robot origin
    assign bin_base  = (r_state == S_BIN) ? r_rrow : r_rcol;
    assign bin_mag   = r_prod[hgm_pkg::MUL_PW-1] ? hgm_pkg::MUL_PW'(-r_prod)
                                                 : hgm_pkg::MUL_PW'(r_prod);
    assign bin_cells = $signed({1'b0, bin_mag[51:24]});
    assign bin_coord = $signed({23'b0, bin_base})
                     + (r_prod[hgm_pkg::MUL_PW-1] ? -bin_cells : bin_cells);
    assign row_ok    = !bin_coord[28] && (bin_coord < 29'(hgm_pkg::GRID_HEIGHT));
    assign col_ok    = !r_col[28] && (r_col < 29'(hgm_pkg::GRID_WIDTH));
    assign add_addr  = hgm_pkg::CELL_AW'(32'(bin_coord) * hgm_pkg::GRID_WIDTH + 32'(r_col));

    assign rd_hits = ram_rdata[hgm_pkg::CELL_W-1:hgm_pkg::AVG_W];
    assign rd_avg  = $signed(ram_rdata[hgm_pkg::AVG_W-1:0]);
    assign rd_mag  = rd_avg[31] ? 32'(-rd_avg) : 32'(rd_avg);

    assign num      = r_prod + hgm_pkg::MUL_PW'(r_pz);
    assign num_mag  = num[hgm_pkg::MUL_PW-1] ? hgm_pkg::MUL_PW'(-num) : hgm_pkg::MUL_PW'(num);
    assign new_avg  = r_neg ? 32'(-div_rsp.quotient) : 32'(div_rsp.quotient);
    assign new_hits = (r_hits == '1) ? r_hits : r_hits + 1'b1;

    always_comb begin
        div_req.start    = (r_state == S_ASUM) || (r_state == S_RMUL);
        div_req.dividend = (r_state == S_ASUM) ? hgm_pkg::DIV_NW'(num_mag)
                                               : hgm_pkg::DIV_NW'(r_prod);
        div_req.divisor  = (r_state == S_ASUM) ? hgm_pkg::DIV_DW'({1'b0, r_hits} + 17'd1)
                                               : r_limit;
    end

    assign ram_raddr = (r_state == S_BIN) ? add_addr : hgm_pkg::CELL_AW'(in_idx);
    assign ram_we    = (r_state == S_CLR) || ((r_state == S_ADIV) && div_rsp.done);
    assign ram_waddr = (r_state == S_CLR) ? r_clr_cnt : r_addr;
    assign ram_wdata = (r_state == S_CLR) ? '0 : {new_hits, new_avg};

    hgm_ram #(
        .WIDTH(hgm_pkg::CELL_W),
        .DEPTH(hgm_pkg::GRID_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hgm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_cnt  <= '0;
            r_clr_item <= 1'b0;
            r_ovalid   <= 1'b0;
            r_scale    <= 16'd512;
            r_limit    <= 31'd524288;
            r_rrow     <= 6'd62;
            r_rcol     <= 6'd32;
            r_offx     <= '0;
            r_offy     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    hgm_pkg::REG_CELL_SCALE:     r_scale <= i_cfg_wdata[15:0];
                    hgm_pkg::REG_OBSTACLE_LIMIT: r_limit <= i_cfg_wdata[30:0];
                    hgm_pkg::REG_ROBOT_ROW:      r_rrow  <= i_cfg_wdata[5:0];
                    hgm_pkg::REG_ROBOT_COL:      r_rcol  <= i_cfg_wdata[5:0];
                    hgm_pkg::REG_OFFSET_X:       r_offx  <= $signed(i_cfg_wdata);
                    hgm_pkg::REG_OFFSET_Y:       r_offy  <= $signed(i_cfg_wdata);
                    default: ;
                endcase
            end

            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == hgm_pkg::CELL_AW'(hgm_pkg::GRID_CELLS - 1)) begin
                        r_state    <= S_IDLE;
                        r_clr_item <= 1'b0;
                        if (r_clr_item) begin
                            r_ovalid <= 1'b1;
                            r_occ    <= '0;
                            r_acc    <= 1'b1;
                        end
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_px  <= $signed(s_axis_tdata[33:2]);
                        r_py  <= $signed(s_axis_tdata[65:34]);
                        r_pz  <= $signed(s_axis_tdata[97:66]);
                        case (in_act)
                            hgm_pkg::ACT_ADD: r_state <= S_MX;
                            hgm_pkg::ACT_READ: begin
                                if (idx_ok) begin
                                    r_state <= S_RCHK;
                                end else begin
                                    r_ovalid <= 1'b1;
                                    r_occ    <= hgm_pkg::OCC_UNKNOWN;
                                    r_acc    <= 1'b1;
                                end
                            end
                            hgm_pkg::ACT_CLEAR: begin
                                r_state    <= S_CLR;
                                r_clr_cnt  <= '0;
                                r_clr_item <= 1'b1;
                            end
                            default: begin
                                r_ovalid <= 1'b1;
                                r_occ    <= '0;
                                r_acc    <= 1'b0;
                            end
                        endcase
                    end
                end
                S_MX: r_state <= S_MY;
                S_MY: begin
                    r_col   <= bin_coord;
                    r_state <= S_BIN;
                end
                S_BIN: begin
                    r_addr <= add_addr;
                    if (row_ok && col_ok) begin
                        r_state <= S_AMUL;
                    end else begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_occ    <= '0;
                        r_acc    <= 1'b0;
                    end
                end
                S_AMUL: begin
                    r_hits  <= rd_hits;
                    r_state <= S_ASUM;
                end
                S_ASUM: begin
                    r_neg   <= num[hgm_pkg::MUL_PW-1];
                    r_state <= S_ADIV;
                end
                S_ADIV: begin
                    if (div_rsp.done) begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_occ    <= '0;
                        r_acc    <= 1'b1;
                    end
                end
                S_RCHK: begin
                    if (rd_hits == '0) begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_occ    <= hgm_pkg::OCC_UNKNOWN;
                        r_acc    <= 1'b1;
                    end else if (rd_mag > {1'b0, r_limit}) begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_occ    <= hgm_pkg::OCC_FULL;
                        r_acc    <= 1'b1;
                    end else if (r_limit == '0) begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_occ    <= '0;
                        r_acc    <= 1'b1;
                    end else begin
                        r_state <= S_RMUL;
                    end
                end
                S_RMUL: r_state <= S_RDIV;
                S_RDIV: begin
                    if (div_rsp.done) begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_occ    <= $signed(div_rsp.quotient[7:0]);
                        r_acc    <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'b0, r_acc, r_occ};

endmodule

FILE: rtl/hgm_checker.sv
// hgm_checker: port-level assertions for height_grid_occupancy_mapper, bound to the top
// depends on hgm_pkg

module hgm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [hgm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) == -8'sd1)
                       || ($signed(m_axis_tdata[7:0]) >= 8'sd0
                           && $signed(m_axis_tdata[7:0]) <= hgm_pkg::OCC_FULL))
        else $error("occupancy out of range");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("rejected request with nonzero occupancy");

endmodule

bind height_grid_occupancy_mapper hgm_checker u_hgm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/height_grid_occupancy_mapper_test.sv
// height_grid_occupancy_mapper_test: self-checking bench for the height grid mapper
// a scoreboard class predicts add/read/clear results; tasks drive the stream and cfg ports
// depends on hgm_pkg and height_grid_occupancy_mapper
`timescale 1ns / 100ps

module height_grid_occupancy_mapper_test;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CLEAR_WAIT = hgm_pkg::GRID_CELLS + 200;

    typedef struct packed {
        logic signed [7:0] occupancy;
        logic              accepted;
    } t_grid_result;

    class occupancy_scoreboard;
        logic [15:0]        cell_scale;
        logic [30:0]        obstacle_limit;
        logic [5:0]         robot_row;
        logic [5:0]         robot_col;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] cell_avg [hgm_pkg::GRID_CELLS];
        logic [15:0]        cell_hits [hgm_pkg::GRID_CELLS];
        t_grid_result       pending [$];
        int                 errors;

        function new();
            cell_scale     = 16'd512;
            obstacle_limit = 31'd524288;
            robot_row      = 6'd62;
            robot_col      = 6'd32;
            offset_x       = 0;
            offset_y       = 0;
            errors         = 0;
            wipe_grid();
        endfunction

        function void wipe_grid();
            foreach (cell_avg[i]) begin
                cell_avg[i]  = 0;
                cell_hits[i] = 0;
            end
        endfunction

        function void write_reg(logic [hgm_pkg::CFG_AW-1:0] idx,
                                logic [hgm_pkg::CFG_DW-1:0] value);
            case (idx)
                hgm_pkg::REG_CELL_SCALE:     cell_scale     = value[15:0];
                hgm_pkg::REG_OBSTACLE_LIMIT: obstacle_limit = value[30:0];
                hgm_pkg::REG_ROBOT_ROW:      robot_row      = value[5:0];
                hgm_pkg::REG_ROBOT_COL:      robot_col      = value[5:0];
                hgm_pkg::REG_OFFSET_X:       offset_x       = value;
                hgm_pkg::REG_OFFSET_Y:       offset_y       = value;
                default: ;
            endcase
        endfunction

        function longint bin_coord(logic signed [31:0] p, logic signed [31:0] off,
                                   logic [5:0] base);
            longint prod;
            longint cells;
            prod = (longint'(p) - longint'(off)) * longint'({48'd0, cell_scale});
            if (prod < 0)
                cells = -((-prod) >>> 24);
            else
                cells = prod >>> 24;
            return longint'({58'd0, base}) + cells;
        endfunction

        function logic signed [7:0] occupancy_of(logic [11:0] idx);
            longint mag;
            if (cell_hits[idx] == 0)
                return hgm_pkg::OCC_UNKNOWN;
            mag = longint'(cell_avg[idx]);
            if (mag < 0)
                mag = -mag;
            if (mag > longint'({33'd0, obstacle_limit}))
                return hgm_pkg::OCC_FULL;
            if (obstacle_limit == 0)
                return 8'sd0;
            return 8'((mag * 100) / longint'({33'd0, obstacle_limit}));
        endfunction

        function void note_request(logic [hgm_pkg::S_TDATA_W-1:0] t);
            t_grid_result       r;
            logic [1:0]         act;
            longint             col;
            longint             row;
            longint             num;
            int                 idx;
            act = t[1:0];
            r   = '0;
            case (act)
                hgm_pkg::ACT_ADD: begin
                    col = bin_coord(t[33:2], offset_x, robot_col);
                    row = bin_coord(t[65:34], offset_y, robot_row);
                    if (col >= 0 && col < hgm_pkg::GRID_WIDTH && row >= 0
                        && row < hgm_pkg::GRID_HEIGHT) begin
                        idx = int'(row * hgm_pkg::GRID_WIDTH + col);
                        num = longint'(cell_avg[idx]) * longint'({48'd0, cell_hits[idx]})
                              + longint'($signed(t[97:66]));
                        cell_avg[idx] = 32'(num / (longint'({48'd0, cell_hits[idx]}) + 1));
                        if (cell_hits[idx] != 16'hFFFF)
                            cell_hits[idx] = cell_hits[idx] + 16'd1;
                        r.accepted = 1'b1;
                    end
                end
                hgm_pkg::ACT_READ: begin
                    r.occupancy = occupancy_of(t[109:98]);
                    r.accepted  = 1'b1;
                end
                hgm_pkg::ACT_CLEAR: begin
                    wipe_grid();
                    r.accepted = 1'b1;
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [hgm_pkg::M_TDATA_W-1:0] d);
            t_grid_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result occupancy %0d accepted %0d",
                             $signed(d[7:0]), d[8]);
                return;
            end
            want = pending.pop_front();
            if (d[7:0] !== want.occupancy || d[8] !== want.accepted) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected occupancy %0d accepted %0d, got %0d %0d",
                             want.occupancy, want.accepted, $signed(d[7:0]), d[8]);
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [hgm_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;  // action, point_x, point_y, point_z, cell_index
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [hgm_pkg::M_TDATA_W-1:0] m_axis_tdata;       // occupancy, accepted
    logic                          i_cfg_we = 1'b0;
    logic [hgm_pkg::CFG_AW-1:0]    i_cfg_addr = '0;
    logic [hgm_pkg::CFG_DW-1:0]    i_cfg_wdata = '0;

    occupancy_scoreboard grid_sb = new();
    bit idle_on = 1'b1;
    bit long_hold = 1'b0;

    always #4 i_clk = ~i_clk;

    height_grid_occupancy_mapper dut (.*);

    // result side: random stalls, one long hold-off on request
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                grid_sb.check_result(m_axis_tdata);
            if (long_hold) begin
                long_hold = 1'b0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(8 * 3_000_000);
        $display("height_grid_occupancy_mapper: mismatch");
        $finish;
    end

    task automatic send_request(logic [1:0] act, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, logic [11:0] idx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, z, y, x, act};
        do @(posedge i_clk); while (!s_axis_tready);
        grid_sb.note_request({2'b00, idx, z, y, x, act});
    endtask

    task automatic write_reg(logic [hgm_pkg::CFG_AW-1:0] idx,
                             logic [hgm_pkg::CFG_DW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        grid_sb.write_reg(idx, value);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (grid_sb.pending.size() != 0) @(posedge i_clk);
        repeat (CLEAR_WAIT) @(posedge i_clk);
    endtask

    task automatic load_config(logic [15:0] scale, logic [30:0] lim, logic [5:0] row,
                               logic [5:0] col, logic [31:0] ox, logic [31:0] oy);
        write_reg(hgm_pkg::REG_CELL_SCALE, {16'd0, scale});
        write_reg(hgm_pkg::REG_OBSTACLE_LIMIT, {1'b0, lim});
        write_reg(hgm_pkg::REG_ROBOT_ROW, {26'd0, row});
        write_reg(hgm_pkg::REG_ROBOT_COL, {26'd0, col});
        write_reg(hgm_pkg::REG_OFFSET_X, ox);
        write_reg(hgm_pkg::REG_OFFSET_Y, oy);
        i_cfg_we <= 1'b0;
    endtask

    // coordinate that lands near a given cell offset from the robot
    function automatic logic [31:0] coord_for(int dcell, logic [31:0] off);
        longint span;
        longint v;
        span = (longint'(1) << 24) / longint'({48'd0, grid_sb.cell_scale});
        v = longint'($signed(off)) + longint'(dcell) * span
            + longint'($urandom_range(0, 1023)) * span / 1024;
        return 32'(v);
    endfunction

    function automatic logic [31:0] rand_height();
        logic [31:0] z;
        z = $urandom;
        return $signed(z) >>> $urandom_range(0, 31);
    endfunction

    task automatic random_requests(int count);
        int          dc;
        int          dr;
        int          pick;
        logic [5:0]  r;
        logic [5:0]  c;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            dc = $urandom_range(0, hgm_pkg::GRID_WIDTH - 1) - int'(grid_sb.robot_col);
            dr = $urandom_range(0, hgm_pkg::GRID_HEIGHT - 1) - int'(grid_sb.robot_row);
            if ($urandom_range(0, 1)) begin
                dc = dc % 3;
                dr = dr % 3;
            end
            c = 6'(int'(grid_sb.robot_col) + dc);
            r = 6'(int'(grid_sb.robot_row) + dr);
            if (pick < 50)
                send_request(hgm_pkg::ACT_ADD,
                             coord_for(dc + $urandom_range(0, 2) - 1, grid_sb.offset_x),
                             coord_for(dr + $urandom_range(0, 2) - 1, grid_sb.offset_y),
                             rand_height(), 12'($urandom));
            else if (pick < 60)
                send_request(hgm_pkg::ACT_ADD, $urandom, $urandom, $urandom, 12'($urandom));
            else if (pick < 88)
                send_request(hgm_pkg::ACT_READ, $urandom, $urandom, $urandom, {r, c});
            else if (pick < 95)
                send_request(hgm_pkg::ACT_READ, $urandom, $urandom, $urandom, 12'($urandom));
            else if (pick < 97)
                send_request(ACT_NONE, $urandom, $urandom, $urandom, 12'($urandom));
            else
                send_request(hgm_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, 12'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);

        // directed: reset config, robot cell is row 62 col 32
        send_request(hgm_pkg::ACT_READ, 0, 0, 0, {6'd62, 6'd32});
        send_request(hgm_pkg::ACT_ADD, 0, 0, 32'h0002_0000, 0);
        send_request(hgm_pkg::ACT_READ, 0, 0, 0, {6'd62, 6'd32});
        send_request(hgm_pkg::ACT_ADD, 32'h0000_7FFF, 32'h0000_7FFF, 32'h7FFF_FFFF, 0);
        send_request(hgm_pkg::ACT_ADD, 0, 0, 32'h8000_0000, 0);
        send_request(hgm_pkg::ACT_READ, 0, 0, 0, {6'd62, 6'd32});
        send_request(hgm_pkg::ACT_ADD, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFF0_0000, 0);
        send_request(hgm_pkg::ACT_READ, 0, 0, 0, {6'd61, 6'd31});
        send_request(hgm_pkg::ACT_ADD, 32'h7FFF_FFFF, 0, 32'h0001_0000, 0);
        send_request(hgm_pkg::ACT_ADD, 32'h8000_0000, 0, 32'h0001_0000, 0);
        send_request(hgm_pkg::ACT_ADD, 0, 32'h7FFF_FFFF, 32'h0001_0000, 0);
        send_request(hgm_pkg::ACT_ADD, 0, 32'h8000_0000, 32'h0001_0000, 0);
        send_request(hgm_pkg::ACT_ADD, 32'hFFF0_0000, 32'h0001_0000, 32'h0001_0000, 0);
        send_request(hgm_pkg::ACT_ADD, 32'h000F_8000, 32'hFFE1_0000, 32'h0008_0001, 0);
        send_request(hgm_pkg::ACT_READ, 0, 0, 0, {6'd0, 6'd63});
        send_request(hgm_pkg::ACT_READ, 0, 0, 0, 12'hFFF);
        send_request(hgm_pkg::ACT_READ, 0, 0, 0, 12'h000);
        send_request(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        send_request(hgm_pkg::ACT_CLEAR, 0, 0, 0, 0);
        send_request(hgm_pkg::ACT_READ, 0, 0, 0, {6'd62, 6'd32});
        random_requests(80);
        settle();

        load_config(16'hFFFF, 31'd1, 6'd0, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        random_requests(80);
        settle();

        load_config(16'd1, 31'h7FFF_FFFF, 6'd63, 6'd63, $urandom, $urandom);
        random_requests(60);
        settle();

        load_config(16'd256, 31'd0, 6'd32, 6'd32, 0, 0);
        send_request(hgm_pkg::ACT_ADD, 0, 0, 0, 0);
        send_request(hgm_pkg::ACT_READ, 0, 0, 0, {6'd32, 6'd32});
        random_requests(60);
        settle();

        load_config(16'($urandom_range(64, 4096)), 31'($urandom_range(1, 32'h0010_0000)),
                    6'($urandom), 6'($urandom), $urandom >> 12, -($urandom >> 12));
        long_hold = 1'b1;
        random_requests(150);
        settle();

        load_config(16'($urandom), 31'($urandom), 6'($urandom), 6'($urandom),
                    $urandom, $urandom);
        random_requests(60);
        settle();

        load_config(16'd512, 31'd524288, 6'd31, 6'd31, 32'($signed($urandom) >>> 14),
                    32'($signed($urandom) >>> 14));
        idle_on = 1'b0;
        random_requests(100);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (grid_sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (grid_sb.errors == 0)
            $display("height_grid_occupancy_mapper: match");
        else
            $display("height_grid_occupancy_mapper: mismatch");
        $finish;
    end

endmodule

FILE: height_grid_occupancy_mapper.f
rtl/hgm_pkg.sv
rtl/hgm_ram.sv
rtl/hgm_div.sv
rtl/height_grid_occupancy_mapper.sv
rtl/hgm_checker.sv
tb/height_grid_occupancy_mapper_test.sv
